// ----- hdl/vau_pkg.sv -----
// Package for the three-component vector unit: opcodes, status codes and
// the control bundle shared by the pipeline stages.
// Depends on nothing; every other file of the unit refers to it by scope.
`timescale 1ns / 1ps
`default_nettype none
package vau_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_SCALE     = 4'd3,
    OP_DIVIDE    = 4'd4,
    OP_NEGATE    = 4'd5,
    OP_DOT       = 4'd6,
    OP_CROSS     = 4'd7,
    OP_LENSQ     = 4'd8,
    OP_LENGTH    = 4'd9,
    OP_NORMALIZE = 4'd10,
    OP_EQUAL     = 4'd11,
    OP_ZERO      = 4'd12
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  localparam int TOL_WIDTH = 31;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd66;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/vector3_arithmetic_unit.sv -----
// Top level of the three-component fixed point vector unit: operand lanes,
// merge stage, square root and divider pipelines and the output buffer.
// Depends on vau_pkg, vau_lane, vau_sqrt and vau_div.
//
//   Channel  Direction  Handshake            Contents
//   in_      input      in_valid / in_stall   opcode, vectors a and b, scalar
//   out_     output     out_valid / out_stall result vector, scalar, flag, status
//   cfg_     input      cfg_valid / cfg_ready tolerance
//
// One transaction per cycle is taken while in_stall is low.
// Reset is synchronous; the tolerance returns to its reset value.
// in_stall rises only when the two-entry output buffer is full.
`timescale 1ns / 1ps
`default_nettype none
module vector3_arithmetic_unit #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [3:0]                          in_opcode,
  input  logic signed [COMP_WIDTH-1:0]        in_a_x,
  input  logic signed [COMP_WIDTH-1:0]        in_a_y,
  input  logic signed [COMP_WIDTH-1:0]        in_a_z,
  input  logic signed [COMP_WIDTH-1:0]        in_b_x,
  input  logic signed [COMP_WIDTH-1:0]        in_b_y,
  input  logic signed [COMP_WIDTH-1:0]        in_b_z,
  input  logic signed [COMP_WIDTH-1:0]        in_scalar_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COMP_WIDTH-1:0]        out_res_x,
  output logic signed [COMP_WIDTH-1:0]        out_res_y,
  output logic signed [COMP_WIDTH-1:0]        out_res_z,
  output logic signed [COMP_WIDTH-1:0]        out_res_scalar,
  output logic                                out_res_flag,
  output logic [1:0]                          out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vau_pkg::TOL_WIDTH-1:0]       cfg_data
);
  localparam int W  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int SW = 2 * W + 2;
  localparam int RW = W + 1;
  localparam int NW = W + F;
  localparam int DW = W + 1;
  localparam int GW = (SW > NW + 1) ? SW : NW + 1;
  localparam int RES_W = 4 * W + 2;
  localparam int TS = 4 + RES_W + 4 * W;
  localparam int TD = 4 + RES_W + RW + 1 + 3;
  localparam int OW = 4 * W + 3;

  function automatic logic [W:0] sat_fn(input logic signed [GW-1:0] v);
    logic signed [GW-1:0] hi;
    logic signed [GW-1:0] lo;
    hi = $signed({{(GW-W+1){1'b0}}, {(W-1){1'b1}}});
    lo = $signed({{(GW-W+1){1'b1}}, {(W-1){1'b0}}});
    if (v > hi) begin
      return {1'b1, hi[W-1:0]};
    end else if (v < lo) begin
      return {1'b1, lo[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  logic [vau_pkg::TOL_WIDTH-1:0] tol_r;
  logic                          en;
  logic [1:0]                    cnt_r;
  logic [1:0]                    cnt_nxt;
  logic [OW-1:0]                 q0_r;
  logic [OW-1:0]                 q1_r;
  logic [OW-1:0]                 q0_nxt;
  logic [OW-1:0]                 q1_nxt;
  logic                          push;
  logic                          pop;
  logic [OW-1:0]                 push_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= vau_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;

  // Operand lanes.
  vau_pkg::pipe_ctl_t    ctl0;
  vau_pkg::pipe_ctl_t    ctl1;
  vau_pkg::pipe_ctl_t    ctl2;
  logic signed [W-1:0]   va [3];
  logic signed [W-1:0]   vb [3];
  logic signed [2*W-1:0] lane_p1  [3];
  logic signed [2*W-1:0] lane_p2  [3];
  logic signed [W:0]     lane_lin [3];
  logic [2:0]            lane_near;
  logic [2:0]            lane_vld;

  assign ctl0  = '{en: en, vld: in_valid};
  assign va[0] = in_a_x;
  assign va[1] = in_a_y;
  assign va[2] = in_a_z;
  assign vb[0] = in_b_x;
  assign vb[1] = in_b_y;
  assign vb[2] = in_b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [W-1:0] m1a;
    logic signed [W-1:0] m1b;
    logic signed [W-1:0] m2a;
    logic signed [W-1:0] m2b;

    always_comb begin
      m1a = va[i];
      m1b = vb[i];
      m2a = '0;
      m2b = '0;
      case (in_opcode)
        vau_pkg::OP_SCALE: begin
          m1b = in_scalar_in;
        end
        vau_pkg::OP_LENSQ, vau_pkg::OP_LENGTH, vau_pkg::OP_NORMALIZE: begin
          m1b = va[i];
        end
        vau_pkg::OP_CROSS: begin
          m1a = va[J];
          m1b = vb[K];
          m2a = vb[J];
          m2b = va[K];
        end
        default: begin
          m1b = vb[i];
        end
      endcase
    end

    vau_lane #(.W(W)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl0),
      .op     (in_opcode),
      .a      (va[i]),
      .b      (vb[i]),
      .m1a    (m1a),
      .m1b    (m1b),
      .m2a    (m2a),
      .m2b    (m2b),
      .tol    (tol_r),
      .vld_o  (lane_vld[i]),
      .p1_o   (lane_p1[i]),
      .p2_o   (lane_p2[i]),
      .lin_o  (lane_lin[i]),
      .near_o (lane_near[i])
    );
  end

  logic [3:0]          s1_op_r;
  logic [3*W-1:0]      s1_a_r;
  logic [W-1:0]        s1_s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r <= in_opcode;
      s1_a_r  <= {in_a_x, in_a_y, in_a_z};
      s1_s_r  <= in_scalar_in;
    end
  end

  // Merge stage.
  logic signed [SW-1:0]  dsum;
  logic signed [2*W:0]   pdiff   [3];
  logic [W:0]            lin_sat [3];
  logic [W:0]            prd_sat [3];
  logic [W:0]            dot_sat;
  logic [W-1:0]          mv      [3];
  logic [W-1:0]          msc;
  logic                  mflag;
  logic                  msat;

  always_comb begin
    dsum    = SW'(lane_p1[0]) + SW'(lane_p1[1]) + SW'(lane_p1[2]);
    dot_sat = sat_fn(GW'(dsum >>> F));
    for (int i = 0; i < 3; i++) begin
      pdiff[i]   = (s1_op_r == vau_pkg::OP_CROSS) ?
                   (2*W+1)'(lane_p1[i]) - (2*W+1)'(lane_p2[i]) : (2*W+1)'(lane_p1[i]);
      prd_sat[i] = sat_fn(GW'(pdiff[i] >>> F));
      lin_sat[i] = sat_fn(GW'(lane_lin[i]));
      mv[i]      = '0;
    end
    msc   = '0;
    mflag = 1'b0;
    msat  = 1'b0;
    case (s1_op_r)
      vau_pkg::OP_ADD, vau_pkg::OP_SUB, vau_pkg::OP_NEGATE: begin
        for (int i = 0; i < 3; i++) begin
          mv[i] = lin_sat[i][W-1:0];
        end
        msat = lin_sat[0][W] | lin_sat[1][W] | lin_sat[2][W];
      end
      vau_pkg::OP_MUL, vau_pkg::OP_SCALE, vau_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          mv[i] = prd_sat[i][W-1:0];
        end
        msat = prd_sat[0][W] | prd_sat[1][W] | prd_sat[2][W];
      end
      vau_pkg::OP_DOT, vau_pkg::OP_LENSQ: begin
        msc  = dot_sat[W-1:0];
        msat = dot_sat[W];
      end
      vau_pkg::OP_EQUAL, vau_pkg::OP_ZERO: begin
        mflag = &lane_near;
      end
      default: begin
        msat = 1'b0;
      end
    endcase
  end

  logic              s2_vld_r;
  logic [SW-1:0]     s2_sum_r;
  logic [TS-1:0]     s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= &lane_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum_r <= dsum;
      s2_tag_r <= {s1_op_r, mv[0], mv[1], mv[2], msc, mflag, msat, s1_a_r, s1_s_r};
    end
  end

  // Square root pipeline.
  logic              sq_vld;
  logic [RW-1:0]     sq_root;
  logic [TS-1:0]     sq_tag;

  assign ctl1 = '{en: en, vld: s2_vld_r};

  vau_sqrt #(.IW(SW), .PW(TS)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl1),
    .num    (s2_sum_r),
    .tag_i  (s2_tag_r),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .tag_o  (sq_tag)
  );

  logic [3:0]          sq_op;
  logic [RES_W-1:0]    sq_res;
  logic [3*W-1:0]      sq_a;
  logic [W-1:0]        sq_s;
  logic                s_neg;
  logic [W-1:0]        s_mag;
  logic [W-1:0]        a_cmp [3];
  logic [2:0][NW-1:0]  dv_num;
  logic [DW-1:0]       dv_den;
  logic                dz;
  logic [2:0]          sgn;

  assign sq_op  = sq_tag[TS-1 -: 4];
  assign sq_res = sq_tag[TS-5 -: RES_W];
  assign sq_a   = sq_tag[4*W-1 -: 3*W];
  assign sq_s   = sq_tag[W-1:0];

  always_comb begin
    s_neg = sq_s[W-1];
    s_mag = s_neg ? (~sq_s + 1'b1) : sq_s;
    for (int i = 0; i < 3; i++) begin
      a_cmp[i]  = sq_a[(2-i)*W +: W];
      dv_num[i] = {(a_cmp[i][W-1] ? (~a_cmp[i] + 1'b1) : a_cmp[i]), {F{1'b0}}};
      sgn[i]    = a_cmp[i][W-1] ^ ((sq_op == vau_pkg::OP_DIVIDE) && s_neg);
    end
    if (sq_op == vau_pkg::OP_NORMALIZE) begin
      dv_den = sq_root;
      dz     = (sq_root == '0);
    end else begin
      dv_den = {1'b0, s_mag};
      dz     = (sq_s == '0);
    end
  end

  // Divider pipeline.
  logic                dv_vld;
  logic [2:0][NW-1:0]  dv_quo;
  logic [TD-1:0]       dv_tag;

  assign ctl2 = '{en: en, vld: sq_vld};

  vau_div #(.NW(NW), .DW(DW), .PW(TD)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl2),
    .num   (dv_num),
    .den   (dv_den),
    .tag_i ({sq_op, sq_res, sq_root, dz, sgn}),
    .vld_o (dv_vld),
    .quo_o (dv_quo),
    .tag_o (dv_tag)
  );

  // Final formatting.
  logic [3:0]            f_op;
  logic [RES_W-1:0]      f_res;
  logic [RW-1:0]         f_root;
  logic                  f_dz;
  logic [2:0]            f_sgn;
  logic signed [GW-1:0]  qe [3];
  logic [W:0]            q_sat [3];
  logic [W:0]            len_sat;
  logic [W-1:0]          fx;
  logic [W-1:0]          fy;
  logic [W-1:0]          fz;
  logic [W-1:0]          fsc;
  logic                  fflag;
  logic [1:0]            fst;

  assign f_op   = dv_tag[TD-1 -: 4];
  assign f_res  = dv_tag[TD-5 -: RES_W];
  assign f_root = dv_tag[RW+3:4];
  assign f_dz   = dv_tag[3];
  assign f_sgn  = dv_tag[2:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qe[i]    = $signed(GW'(dv_quo[i]));
      q_sat[i] = sat_fn(f_sgn[i] ? -qe[i] : qe[i]);
    end
    len_sat = sat_fn($signed(GW'(f_root)));
    fx    = f_res[4*W+1 -: W];
    fy    = f_res[3*W+1 -: W];
    fz    = f_res[2*W+1 -: W];
    fsc   = f_res[W+1 -: W];
    fflag = f_res[1];
    fst   = f_res[0] ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
    case (f_op)
      vau_pkg::OP_DIVIDE, vau_pkg::OP_NORMALIZE: begin
        if (f_dz) begin
          fx  = '0;
          fy  = '0;
          fz  = '0;
          fst = vau_pkg::ST_DIV0;
        end else begin
          fx  = q_sat[0][W-1:0];
          fy  = q_sat[1][W-1:0];
          fz  = q_sat[2][W-1:0];
          fst = (q_sat[0][W] | q_sat[1][W] | q_sat[2][W]) ?
                vau_pkg::ST_SAT : vau_pkg::ST_OK;
        end
      end
      vau_pkg::OP_LENGTH: begin
        fsc = len_sat[W-1:0];
        fst = len_sat[W] ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
      end
      default: begin
        fflag = f_res[1];
      end
    endcase
  end

  assign push_data = {fx, fy, fz, fsc, fflag, fst};

  // Two-entry output buffer.
  assign push      = en && dv_vld;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q0_nxt = push_data;
        end else begin
          q1_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt  = q1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          q0_nxt = push_data;
        end else begin
          q0_nxt = q1_r;
          q1_nxt = push_data;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_res_x      = q0_r[OW-1 -: W];
  assign out_res_y      = q0_r[OW-W-1 -: W];
  assign out_res_z      = q0_r[OW-2*W-1 -: W];
  assign out_res_scalar = q0_r[OW-3*W-1 -: W];
  assign out_res_flag   = q0_r[2];
  assign out_status     = q0_r[1:0];

endmodule
`default_nettype wire

// ----- hdl/vau_lane.sv -----
// One component lane: two signed multipliers, the add, subtract and negate
// path and the tolerance test, all registered.
// Depends on vau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vau_lane #(
  parameter int W = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vau_pkg::pipe_ctl_t                  ctl,
  input  logic [3:0]                          op,
  input  logic signed [W-1:0]                 a,
  input  logic signed [W-1:0]                 b,
  input  logic signed [W-1:0]                 m1a,
  input  logic signed [W-1:0]                 m1b,
  input  logic signed [W-1:0]                 m2a,
  input  logic signed [W-1:0]                 m2b,
  input  logic [vau_pkg::TOL_WIDTH-1:0]       tol,
  output logic                                vld_o,
  output logic signed [2*W-1:0]               p1_o,
  output logic signed [2*W-1:0]               p2_o,
  output logic signed [W:0]                   lin_o,
  output logic                                near_o
);
  localparam int CW = (W + 1 > vau_pkg::TOL_WIDTH) ? W + 1 : vau_pkg::TOL_WIDTH;

  logic signed [W:0]     a_e;
  logic signed [W:0]     b_e;
  logic signed [W:0]     d;
  logic [W:0]            d_mag;
  logic signed [W:0]     lin_nxt;
  logic                  near_nxt;
  logic signed [2*W-1:0] p1_nxt;
  logic signed [2*W-1:0] p2_nxt;

  logic                  vld_r;
  logic signed [2*W-1:0] p1_r;
  logic signed [2*W-1:0] p2_r;
  logic signed [W:0]     lin_r;
  logic                  near_r;

  always_comb begin
    a_e = (W+1)'(a);
    b_e = (W+1)'(b);
    case (op)
      vau_pkg::OP_ADD: begin
        lin_nxt = a_e + b_e;
      end
      vau_pkg::OP_SUB: begin
        lin_nxt = a_e - b_e;
      end
      default: begin
        lin_nxt = -a_e;
      end
    endcase
    d        = (op == vau_pkg::OP_EQUAL) ? a_e - b_e : a_e;
    d_mag    = d[W] ? $unsigned(-d) : $unsigned(d);
    near_nxt = (CW'(d_mag) <= CW'(tol));
    p1_nxt   = m1a * m1b;
    p2_nxt   = m2a * m2b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.en) begin
      vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      lin_r  <= lin_nxt;
      near_r <= near_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign p1_o   = p1_r;
  assign p2_o   = p2_r;
  assign lin_o  = lin_r;
  assign near_o = near_r;

endmodule
`default_nettype wire

// ----- hdl/vau_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, carrying a tag
// alongside each transaction.
// Depends on vau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vau_sqrt #(
  parameter int IW = 66,
  parameter int PW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vau_pkg::pipe_ctl_t ctl,
  input  logic [IW-1:0]      num,
  input  logic [PW-1:0]      tag_i,
  output logic               vld_o,
  output logic [IW/2-1:0]    root_o,
  output logic [PW-1:0]      tag_o
);
  localparam int RW = IW / 2;

  logic [IW-1:0] n_r   [RW];
  logic [RW-1:0] q_r   [RW];
  logic [RW:0]   rm_r  [RW];
  logic          vld_r [RW];
  logic [PW-1:0] tag_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [IW-1:0] n_prv;
    logic [RW-1:0] q_prv;
    logic [RW:0]   rm_prv;
    logic          vld_prv;
    logic [PW-1:0] tag_prv;
    logic [RW+1:0] rt;
    logic [RW+1:0] trial;
    logic          ge;
    logic [IW-1:0] n_nxt;
    logic [RW-1:0] q_nxt;
    logic [RW:0]   rm_nxt;

    if (k == 0) begin : g_first
      assign n_prv   = num;
      assign q_prv   = '0;
      assign rm_prv  = '0;
      assign vld_prv = ctl.vld;
      assign tag_prv = tag_i;
    end else begin : g_next
      assign n_prv   = n_r[k-1];
      assign q_prv   = q_r[k-1];
      assign rm_prv  = rm_r[k-1];
      assign vld_prv = vld_r[k-1];
      assign tag_prv = tag_r[k-1];
    end

    assign rt     = {rm_prv[RW-1:0], n_prv[IW-1 -: 2]};
    assign trial  = {q_prv, 2'b01};
    assign ge     = (rt >= trial);
    assign rm_nxt = ge ? (RW+1)'(rt - trial) : rt[RW:0];
    assign q_nxt  = {q_prv[RW-2:0], ge};
    assign n_nxt  = {n_prv[IW-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_prv;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        n_r[k]   <= n_nxt;
        q_r[k]   <= q_nxt;
        rm_r[k]  <= rm_nxt;
        tag_r[k] <= tag_prv;
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = q_r[RW-1];
  assign tag_o  = tag_r[RW-1];

endmodule
`default_nettype wire

// ----- hdl/vau_div.sv -----
// Pipelined restoring divider for three numerators over one shared
// denominator, one quotient bit per stage, with a tag carried alongside.
// Depends on vau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vau_div #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int PW = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vau_pkg::pipe_ctl_t    ctl,
  input  logic [2:0][NW-1:0]    num,
  input  logic [DW-1:0]         den,
  input  logic [PW-1:0]         tag_i,
  output logic                  vld_o,
  output logic [2:0][NW-1:0]    quo_o,
  output logic [PW-1:0]         tag_o
);
  logic [2:0][NW-1:0] nq_r  [NW];
  logic [2:0][DW-1:0] rm_r  [NW];
  logic [DW-1:0]      d_r   [NW];
  logic               vld_r [NW];
  logic [PW-1:0]      tag_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [2:0][NW-1:0] nq_prv;
    logic [2:0][DW-1:0] rm_prv;
    logic [DW-1:0]      d_prv;
    logic               vld_prv;
    logic [PW-1:0]      tag_prv;
    logic [2:0][NW-1:0] nq_nxt;
    logic [2:0][DW-1:0] rm_nxt;

    if (k == 0) begin : g_first
      assign nq_prv  = num;
      assign rm_prv  = '0;
      assign d_prv   = den;
      assign vld_prv = ctl.vld;
      assign tag_prv = tag_i;
    end else begin : g_next
      assign nq_prv  = nq_r[k-1];
      assign rm_prv  = rm_r[k-1];
      assign d_prv   = d_r[k-1];
      assign vld_prv = vld_r[k-1];
      assign tag_prv = tag_r[k-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_sub
      logic [DW:0] rt;
      logic        ge;
      assign rt        = {rm_prv[l], nq_prv[l][NW-1]};
      assign ge        = (rt >= {1'b0, d_prv});
      assign rm_nxt[l] = ge ? DW'(rt - {1'b0, d_prv}) : rt[DW-1:0];
      assign nq_nxt[l] = {nq_prv[l][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[k] <= vld_prv;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        nq_r[k]  <= nq_nxt;
        rm_r[k]  <= rm_nxt;
        d_r[k]   <= d_prv;
        tag_r[k] <= tag_prv;
      end
    end
  end

  assign vld_o = vld_r[NW-1];
  assign quo_o = nq_r[NW-1];
  assign tag_o = tag_r[NW-1];

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the three-component vector unit: directed table
// followed by random transactions, checked against a behavioral predictor.
// Depends on vau_pkg and vector3_arithmetic_unit.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [3:0] op;
    logic signed [31:0] ax, ay, az, bx, by, bz, sc;
  } vec_op_t;

  typedef struct packed {
    logic signed [31:0] x, y, z, s;
    logic flag;
    logic [1:0] st;
  } vec_res_t;

  typedef struct {
    vec_op_t op;
    logic known;
    vec_res_t res;
  } table_row_t;

  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam int LATENCY = 84;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_opcode = '0;
  logic signed [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_scalar_in = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] out_res_x, out_res_y, out_res_z, out_res_scalar;
  logic out_res_flag;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vau_pkg::TOL_WIDTH-1:0] cfg_data = '0;

  logic [30:0] tol_model;
  vec_res_t pending_results[$];
  int errors = 0;
  int long_hold = 0;
  bit stim_done = 0;

  vector3_arithmetic_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_scalar_in(in_scalar_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_x(out_res_x), .out_res_y(out_res_y), .out_res_z(out_res_z),
    .out_res_scalar(out_res_scalar), .out_res_flag(out_res_flag),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic signed [31:0] clamp(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return MAXV;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return MINV;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
    logic [127:0] mn, md, q;
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    q = mn / md;
    return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
    logic [63:0] r, c;
    r = 0;
    for (int i = 49; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic bit close_enough(input logic signed [127:0] d);
    return (d < 0 ? -d : d) <= $signed({97'd0, tol_model});
  endfunction

  function automatic vec_res_t predict_vector_op(input vec_op_t o);
    vec_res_t r;
    logic signed [127:0] a[3], b[3], s, t, sumsq;
    logic signed [31:0] v[3];
    logic [63:0] len;
    bit sat, div0;
    sat = 0;
    div0 = 0;
    a[0] = o.ax; a[1] = o.ay; a[2] = o.az;
    b[0] = o.bx; b[1] = o.by; b[2] = o.bz;
    s = o.sc;
    r = '{default: '0};
    v = '{default: '0};
    sumsq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    case (o.op)
      vau_pkg::OP_ADD, vau_pkg::OP_SUB, vau_pkg::OP_MUL, vau_pkg::OP_SCALE,
      vau_pkg::OP_NEGATE: begin
        for (int i = 0; i < 3; i++) begin
          case (o.op)
            vau_pkg::OP_ADD: t = a[i] + b[i];
            vau_pkg::OP_SUB: t = a[i] - b[i];
            vau_pkg::OP_MUL: t = (a[i] * b[i]) >>> 16;
            vau_pkg::OP_SCALE: t = (a[i] * s) >>> 16;
            default: t = -a[i];
          endcase
          v[i] = clamp(t, sat);
        end
      end
      vau_pkg::OP_DIVIDE: begin
        if (s == 0) div0 = 1;
        else for (int i = 0; i < 3; i++) v[i] = clamp(quot_trunc(a[i] <<< 16, s), sat);
      end
      vau_pkg::OP_DOT: r.s = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16, sat);
      vau_pkg::OP_CROSS: begin
        v[0] = clamp((a[1] * b[2] - b[1] * a[2]) >>> 16, sat);
        v[1] = clamp((b[0] * a[2] - a[0] * b[2]) >>> 16, sat);
        v[2] = clamp((a[0] * b[1] - b[0] * a[1]) >>> 16, sat);
      end
      vau_pkg::OP_LENSQ: r.s = clamp(sumsq >>> 16, sat);
      vau_pkg::OP_LENGTH: r.s = clamp($signed({64'd0, floor_sqrt(sumsq)}), sat);
      vau_pkg::OP_NORMALIZE: begin
        len = floor_sqrt(sumsq);
        if (len == 0) div0 = 1;
        else for (int i = 0; i < 3; i++)
          v[i] = clamp(quot_trunc(a[i] <<< 16, $signed({64'd0, len})), sat);
      end
      vau_pkg::OP_EQUAL: r.flag = close_enough(a[0] - b[0]) && close_enough(a[1] - b[1])
                                  && close_enough(a[2] - b[2]);
      vau_pkg::OP_ZERO: r.flag = close_enough(a[0]) && close_enough(a[1])
                                 && close_enough(a[2]);
      default: ;
    endcase
    r.x = v[0];
    r.y = v[1];
    r.z = v[2];
    r.st = div0 ? vau_pkg::ST_DIV0 : (sat ? vau_pkg::ST_SAT : vau_pkg::ST_OK);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    vec_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t result with no pending transaction", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (out_res_x !== e.x) report_mismatch("res_x", out_res_x, e.x);
        if (out_res_y !== e.y) report_mismatch("res_y", out_res_y, e.y);
        if (out_res_z !== e.z) report_mismatch("res_z", out_res_z, e.z);
        if (out_res_scalar !== e.s) report_mismatch("res_scalar", out_res_scalar, e.s);
        if (out_res_flag !== e.flag) report_mismatch("res_flag", out_res_flag, e.flag);
        if (out_status !== e.st) report_mismatch("status", out_status, e.st);
      end
    end
  end

  initial begin
    int wait_cycles;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (!stim_done) begin
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall) && long_hold == 0 && !stim_done) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  task automatic send_item(input vec_op_t o, input bit check_known, input vec_res_t known);
    vec_res_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= o.op;
    in_a_x <= o.ax; in_a_y <= o.ay; in_a_z <= o.az;
    in_b_x <= o.bx; in_b_y <= o.by; in_b_z <= o.bz;
    in_scalar_in <= o.sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_vector_op(o);
    if (check_known && p != known) begin
      errors++;
      $display("predictor disagrees with table row for opcode %0d", o.op);
    end
    pending_results.push_back(check_known ? known : p);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [30:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tol_model = value;
  endtask

  function automatic logic signed [31:0] rand_comp(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return ($urandom_range(0, 1) ? MAXV : MINV) - $urandom_range(0, 2);
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  function automatic vec_op_t rand_op(input logic [30:0] tol);
    vec_op_t o;
    int m;
    m = $urandom_range(0, 3);
    o.op = ($urandom_range(0, 40) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12);
    o.ax = rand_comp(m); o.ay = rand_comp(m); o.az = rand_comp(m);
    o.bx = rand_comp(m); o.by = rand_comp(m); o.bz = rand_comp(m);
    o.sc = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_comp($urandom_range(0, 3));
    if (o.op inside {vau_pkg::OP_EQUAL, vau_pkg::OP_ZERO} && $urandom_range(0, 1)) begin
      o.ax = $signed($urandom_range(0, 2 * (tol % 1000) + 2)) - $signed(tol % 1000) - 1;
      o.ay = $signed($urandom_range(0, 2 * (tol % 1000) + 2)) - $signed(tol % 1000) - 1;
      o.az = $signed($urandom_range(0, 2 * (tol % 1000) + 2)) - $signed(tol % 1000) - 1;
      if (o.op == vau_pkg::OP_EQUAL) begin
        o.bx = o.ax + $signed($urandom_range(0, 2 * tol + 2)) - $signed(tol) - 1;
        o.by = o.ay + $signed($urandom_range(0, 2 * tol + 2)) - $signed(tol) - 1;
        o.bz = o.az + $signed($urandom_range(0, 2 * tol + 2)) - $signed(tol) - 1;
      end
    end
    return o;
  endfunction

  table_row_t directed[$];

  initial begin
    logic [30:0] tol_settings[5];
    vec_res_t z;
    vec_op_t o;
    tol_settings = '{31'd0, 31'h7fffffff, 31'd1000, 31'd66, 31'd5};
    tol_model = vau_pkg::TOL_RESET;
    z = '{default: '0};
    directed.push_back('{'{vau_pkg::OP_ADD, ONE, 2 * ONE, -ONE, ONE, ONE, ONE, 0}, 1,
                        '{2 * ONE, 3 * ONE, 0, 0, 0, vau_pkg::ST_OK}});
    directed.push_back('{'{vau_pkg::OP_ADD, MAXV, MINV, MAXV, MAXV, MINV, 1, 0}, 1,
                        '{MAXV, MINV, MAXV, 0, 0, vau_pkg::ST_SAT}});
    directed.push_back('{'{vau_pkg::OP_SUB, MINV, MAXV, 0, 1, -1, 0, 0}, 1,
                        '{MINV, MAXV, 0, 0, 0, vau_pkg::ST_SAT}});
    directed.push_back('{'{vau_pkg::OP_MUL, MAXV, MINV, -1, MAXV, MINV, 1, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_SCALE, ONE, -ONE, MAXV, 0, 0, 0, MINV}, 0, z});
    directed.push_back('{'{vau_pkg::OP_DIVIDE, ONE, MAXV, MINV, 0, 0, 0, 0}, 1,
                        '{0, 0, 0, 0, 0, vau_pkg::ST_DIV0}});
    directed.push_back('{'{vau_pkg::OP_DIVIDE, MAXV, MINV, 3, 0, 0, 0, 1}, 0, z});
    directed.push_back('{'{vau_pkg::OP_DIVIDE, -3, 7, ONE, 0, 0, 0, -2 * ONE}, 0, z});
    directed.push_back('{'{vau_pkg::OP_NEGATE, MINV, MAXV, 0, 0, 0, 0, 0}, 1,
                        '{MAXV, -MAXV, 0, 0, 0, vau_pkg::ST_SAT}});
    directed.push_back('{'{vau_pkg::OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0}, 1,
                        '{0, 0, 0, MAXV, 0, vau_pkg::ST_SAT}});
    directed.push_back('{'{vau_pkg::OP_DOT, ONE, 2 * ONE, 3 * ONE, ONE, ONE, -ONE, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0}, 1,
                        '{0, 0, ONE, 0, 0, vau_pkg::ST_OK}});
    directed.push_back('{'{vau_pkg::OP_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_LENSQ, MINV, MAXV, MINV, 0, 0, 0, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_LENGTH, MINV, MINV, MINV, 0, 0, 0, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_LENGTH, 3, 4, 0, 0, 0, 0, 0}, 1,
                        '{0, 0, 0, 5, 0, vau_pkg::ST_OK}});
    directed.push_back('{'{vau_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0}, 1,
                        '{0, 0, 0, 0, 0, vau_pkg::ST_DIV0}});
    directed.push_back('{'{vau_pkg::OP_NORMALIZE, 1, 0, 0, 0, 0, 0, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_NORMALIZE, MAXV, MINV, 5, 0, 0, 0, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_EQUAL, 66, -66, 0, 0, 0, 0, 0}, 1,
                        '{0, 0, 0, 0, 1, vau_pkg::ST_OK}});
    directed.push_back('{'{vau_pkg::OP_EQUAL, 67, 0, 0, 0, 0, 0, 0}, 1,
                        '{0, 0, 0, 0, 0, vau_pkg::ST_OK}});
    directed.push_back('{'{vau_pkg::OP_EQUAL, MAXV, 0, 0, MINV, 0, 0, 0}, 0, z});
    directed.push_back('{'{vau_pkg::OP_ZERO, -66, 66, 0, 0, 0, 0, 0}, 1,
                        '{0, 0, 0, 0, 1, vau_pkg::ST_OK}});
    directed.push_back('{'{vau_pkg::OP_ZERO, MINV, 0, 0, 0, 0, 0, 0}, 1,
                        '{0, 0, 0, 0, 0, vau_pkg::ST_OK}});
    directed.push_back('{'{4'd15, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 1, z});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].op, directed[i].known, directed[i].res);
    drain_and_idle();

    foreach (tol_settings[k]) begin
      write_tolerance(tol_settings[k]);
      for (int n = 0; n < 320; n++) begin
        if (k == 1 && n == 40) long_hold = 300;
        if (k == 2 && n == 100) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
        end
        o = rand_op(tol_model);
        send_item(o, 0, z);
      end
      drain_and_idle();
    end

    stim_done = 1;
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ----- vector3_arithmetic_unit.f -----
hdl/vau_pkg.sv
hdl/vau_lane.sv
hdl/vau_sqrt.sv
hdl/vau_div.sv
hdl/vector3_arithmetic_unit.sv
tb/testbench.sv
